// ----- rtl/tdpe_pkg.sv -----
package tdpe_pkg;

   // default field widths and limits
   localparam int VALUE_BITS_DEF = 31;
   localparam int MAX_COUNT_DEF  = 64;
   localparam int COUNT_BITS     = 7;
   localparam int RESULT_BITS    = 32;

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } tdpe_div_stat_type;

endpackage

// ----- rtl/tdpe_if.sv -----
interface tdpe_req_if #(
   parameter int VALUE_BITS = tdpe_pkg::VALUE_BITS_DEF
);
   import tdpe_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [VALUE_BITS-1:0] value;
   logic [COUNT_BITS-1:0] count;

   modport source (output valid, command, value, count, input ready);
   modport sink   (input valid, command, value, count, output ready);
endinterface

interface tdpe_rsp_if;
   import tdpe_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [RESULT_BITS-1:0] result_value;
   logic                   none_found;
   logic                   is_last;

   modport source (output valid, result_value, none_found, is_last, input ready);
   modport sink   (input valid, result_value, none_found, is_last, output ready);
endinterface

// ----- rtl/tdpe_divider.sv -----
module tdpe_divider #(
   parameter int W = tdpe_pkg::VALUE_BITS_DEF + 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [W-1:0]               dividend,
   input  logic [W-1:0]               divisor,
   output logic [W-1:0]               quotient,
   output logic [W-1:0]               remainder,
   output tdpe_pkg::tdpe_div_stat_type stat
);
   import tdpe_pkg::*;

   localparam int CW = $clog2(W + 1);

   // restoring division, one quotient bit per cycle
   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    rem_sh;
   logic [W+1:0]  diff;

   always_comb begin
      rem_sh  = {rem_ff[W-1:0], quo_ff[W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[W+1]) begin
            rem_in = diff[W:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff[W-1:0];
   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;

endmodule

// ----- rtl/trial_division_prime_engine_core.sv -----
// Cost: every trial division runs through a bit-serial divider of width W = VALUE_BITS+2,
// with sequencing around each one, so the work for an item grows with the number of trial
// divisions (about sqrt(value) per factor search or per prime tested).
// Throughput: one item at a time; the next request is taken once the last result is loaded.
// Reset: synchronous, active high; clears the sequencer, divider control and output valid.
module trial_division_prime_engine_core #(
   parameter int VALUE_BITS = tdpe_pkg::VALUE_BITS_DEF,
   parameter int MAX_COUNT  = tdpe_pkg::MAX_COUNT_DEF
) (
   input logic       clock,
   input logic       reset,
   tdpe_req_if.sink  req_chan,
   tdpe_rsp_if.source rsp_chan
);
   import tdpe_pkg::*;

   // Working width: next-primes search may run past 2^VALUE_BITS, two spare bits cover it.
   localparam int W = VALUE_BITS + 2;
   localparam logic [W-1:0] ONE = W'(1);
   localparam logic [W-1:0] TWO = W'(2);
   localparam logic [W-1:0] FOUR = W'(4);

   typedef enum logic [2:0] {
      S_IDLE,   // waiting for a request transfer
      S_FDIV,   // factor mode: waiting on the divider
      S_FEMIT,  // factor mode: new factor found, shuffle through the hold register
      S_FLAST,  // factor mode: final result (or none found)
      S_PDIV,   // next-primes: waiting on the divider
      S_PEMIT   // next-primes: candidate proved prime, send it
   } state_type;

   state_type              state_ff, state_in;
   logic [W-1:0]           m_ff, m_in;        // remainder being factored / prime candidate
   logic [W-1:0]           d_ff, d_in;        // trial divisor
   logic [W-1:0]           val_ff, val_in;    // original value in factor mode
   logic [W-1:0]           pend_ff, pend_in;  // factor held back until we know if it is last
   logic                   pend_valid_ff, pend_valid_in;
   logic                   strip_ff, strip_in; // dividing out repeats of a found factor
   logic                   fin_ff, fin_in;     // trial loop finished, leftover is a factor
   logic [COUNT_BITS-1:0]  left_ff, left_in;   // primes still to send
   logic                   start_ff, start_in;
   logic                   out_valid_ff, out_valid_in;
   logic [RESULT_BITS-1:0] out_value_ff, out_value_in;
   logic                   out_none_ff, out_none_in;
   logic                   out_last_ff, out_last_in;

   logic [W-1:0]           div_quo;
   logic [W-1:0]           div_rem;
   tdpe_div_stat_type      div_stat;
   logic                   out_free;
   logic [W-1:0]           d_inc;
   logic [W-1:0]           req_val;
   logic [COUNT_BITS-1:0]  req_cnt;

   // Shared divider: operands sampled from m_ff / d_ff on the start pulse.
   tdpe_divider #(
      .W (W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (m_ff),
      .divisor   (d_ff),
      .quotient  (div_quo),
      .remainder (div_rem),
      .stat      (div_stat)
   );

   // Output register loads when empty or when its content is transferred this cycle.
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign d_inc    = d_ff + ONE;
   assign req_val  = W'(req_chan.value);
   // count saturates at MAX_COUNT
   assign req_cnt  = (req_chan.count > COUNT_BITS'(MAX_COUNT)) ?
                     COUNT_BITS'(MAX_COUNT) : req_chan.count;

   always_comb begin
      state_in      = state_ff;
      m_in          = m_ff;
      d_in          = d_ff;
      val_in        = val_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      strip_in      = strip_ff;
      fin_in        = fin_ff;
      left_in       = left_ff;
      start_in      = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_value_in  = out_value_ff;
      out_none_in   = out_none_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               d_in = TWO;
               if (!req_chan.command) begin
                  val_in        = req_val;
                  m_in          = req_val;
                  pend_valid_in = 1'b0;
                  strip_in      = 1'b0;
                  fin_in        = 1'b0;
                  if (req_val < FOUR) begin
                     state_in = S_FLAST;
                  end else begin
                     start_in = 1'b1;
                     state_in = S_FDIV;
                  end
               end else begin
                  left_in = req_cnt;
                  // smallest prime above 0 or 1 is 2
                  m_in    = (req_val < TWO) ? TWO : req_val + ONE;
                  if (req_cnt != '0) begin
                     start_in = 1'b1;
                     state_in = S_PDIV;
                  end
               end
            end
         end

         S_FDIV: begin
            if (div_stat.done) begin
               if (strip_ff) begin
                  // keep dividing out d until it no longer goes
                  if (div_rem == '0) begin
                     m_in = div_quo;
                  end else begin
                     strip_in = 1'b0;
                     d_in     = d_inc;
                  end
                  start_in = 1'b1;
               end else if (d_ff > div_quo) begin
                  // d*d > m: trial loop over; a leftover above 1, unless it is the value itself, is the largest factor
                  fin_in = 1'b1;
                  if (m_ff > ONE && m_ff != val_ff) begin
                     state_in = S_FEMIT;
                  end else begin
                     state_in = S_FLAST;
                  end
               end else if (div_rem == '0) begin
                  m_in     = div_quo;
                  strip_in = 1'b1;
                  fin_in   = 1'b0;
                  state_in = S_FEMIT;
               end else begin
                  d_in     = d_inc;
                  start_in = 1'b1;
               end
            end
         end

         S_FEMIT: begin
            // previous held factor is not the last one: push it out, hold the new one
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_value_in = RESULT_BITS'(pend_ff);
                  out_none_in  = 1'b0;
                  out_last_in  = 1'b0;
               end
               pend_in       = fin_ff ? m_ff : d_ff;
               pend_valid_in = 1'b1;
               if (fin_ff) begin
                  state_in = S_FLAST;
               end else begin
                  start_in = 1'b1;
                  state_in = S_FDIV;
               end
            end
         end

         S_FLAST: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_last_in   = 1'b1;
               out_none_in   = !pend_valid_ff;
               out_value_in  = pend_valid_ff ? RESULT_BITS'(pend_ff) : '0;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         S_PDIV: begin
            if (div_stat.done) begin
               if (d_ff > div_quo) begin
                  state_in = S_PEMIT;
               end else if (div_rem == '0) begin
                  // composite: move to the next candidate
                  m_in     = m_ff + ONE;
                  d_in     = TWO;
                  start_in = 1'b1;
               end else begin
                  d_in     = d_inc;
                  start_in = 1'b1;
               end
            end
         end

         S_PEMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = RESULT_BITS'(m_ff);
               out_none_in  = 1'b0;
               out_last_in  = (left_ff == COUNT_BITS'(1));
               left_in      = left_ff - 1'b1;
               if (left_ff == COUNT_BITS'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  m_in     = m_ff + ONE;
                  d_in     = TWO;
                  start_in = 1'b1;
                  state_in = S_PDIV;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         strip_ff      <= 1'b0;
         fin_ff        <= 1'b0;
         left_ff       <= '0;
         start_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         strip_ff      <= strip_in;
         fin_ff        <= fin_in;
         left_ff       <= left_in;
         start_ff      <= start_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff         <= m_in;
      d_ff         <= d_in;
      val_ff       <= val_in;
      pend_ff      <= pend_in;
      out_value_ff <= out_value_in;
      out_none_ff  <= out_none_in;
      out_last_ff  <= out_last_in;
   end

   // Request transfer only while idle; results leave through the output register.
   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.result_value = out_value_ff;
   assign rsp_chan.none_found   = out_none_ff;
   assign rsp_chan.is_last      = out_last_ff;

   // divider is never restarted mid-division
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> !div_stat.busy)
      else $error("divider started while busy");

   // a none-found item is always the only and last one, with a zero value
   a_none_form: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_none_ff) |-> (out_last_ff && out_value_ff == '0))
      else $error("malformed none-found result");

   // prime search only runs with primes still owed
   a_pdiv_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PDIV || state_ff == S_PEMIT) |-> (left_ff != '0))
      else $error("prime search with zero count left");

   // a held factor only exists inside a factor run
   a_pend_factor: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |->
         (state_ff == S_FDIV || state_ff == S_FEMIT || state_ff == S_FLAST))
      else $error("held factor outside factor mode");

endmodule
